FILE: rtl/rmq_pkg.sv
// Shared types and constants of the rotation-matrix to quaternion converter.
// Used by every module of the block; depends on nothing.
package rmq_pkg;

    localparam int FRAC_BITS = 14;
    localparam int IN_W      = 16;
    localparam int OUT_W     = 16;
    localparam int SUM_W     = IN_W + 2;
    localparam int MAG_W     = IN_W + 1;
    localparam int RAD_W     = (FRAC_BITS + 2 > SUM_W) ? FRAC_BITS + 2 : SUM_W;
    localparam int SQ_W      = ((RAD_W + FRAC_BITS + 1) / 2) * 2;
    localparam int RT_W      = SQ_W / 2;
    localparam int RM_W      = RT_W + 3;
    localparam int QB        = OUT_W + 1;
    localparam int DV_W      = MAG_W + FRAC_BITS;
    localparam int DIV_W     = (DV_W > RT_W + 1 + QB) ? DV_W : RT_W + 1 + QB;
    localparam int FIFO_AW   = 2;
    localparam int FIFO_DEPTH = 1 << FIFO_AW;
    localparam int OUT_MAX   = (1 << (OUT_W - 1)) - 1;

    typedef enum logic [1:0] {
        COMP_X = 2'd0,
        COMP_Y = 2'd1,
        COMP_Z = 2'd2,
        COMP_W = 2'd3
    } comp_t;

    // Numerators of the four components; the root component's slot is zero
    typedef struct packed {
        comp_t                 root;
        logic [3:0]            neg;
        logic [3:0][MAG_W-1:0] mag;
    } rmq_num_t;

    typedef struct packed {
        rmq_num_t         num;
        logic [RAD_W-1:0] rad;
    } rmq_item_t;

endpackage

FILE: rtl/rotation_matrix_to_quaternion.sv
// Top level of the rotation-matrix to quaternion converter (Shepperd's method).
// Depends on rmq_pkg, rmq_front, rmq_fifo and rmq_back.
//
//   channel  direction  handshake            payload
//   s_       in         s_valid / s_ready    s_m00 .. s_m22, signed Q1.14
//   m_       out        m_valid / m_ready    m_quat_x/y/z/w Q1.14, m_saturated
//
// One matrix per cycle is taken and one quaternion per cycle delivered while m_ready stays high.
// The path runs through one front stage, one queue slot, RT_W square-root stages plus
// set-up, a divider set-up stage, QB divider stages and the output register.
// Reset (aresetn low, synchronous) empties the front, queue and pipeline.
// A stall on m_ready freezes the back pipeline; the front keeps taking
// transfers until the queue is full, then drops s_ready.
module rotation_matrix_to_quaternion (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [rmq_pkg::IN_W-1:0] s_m00,
    input  logic signed [rmq_pkg::IN_W-1:0] s_m01,
    input  logic signed [rmq_pkg::IN_W-1:0] s_m02,
    input  logic signed [rmq_pkg::IN_W-1:0] s_m10,
    input  logic signed [rmq_pkg::IN_W-1:0] s_m11,
    input  logic signed [rmq_pkg::IN_W-1:0] s_m12,
    input  logic signed [rmq_pkg::IN_W-1:0] s_m20,
    input  logic signed [rmq_pkg::IN_W-1:0] s_m21,
    input  logic signed [rmq_pkg::IN_W-1:0] s_m22,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [rmq_pkg::OUT_W-1:0] m_quat_x,
    output logic signed [rmq_pkg::OUT_W-1:0] m_quat_y,
    output logic signed [rmq_pkg::OUT_W-1:0] m_quat_z,
    output logic signed [rmq_pkg::OUT_W-1:0] m_quat_w,
    output logic                          m_saturated
);
    import rmq_pkg::*;

    logic      fifo_full, fifo_empty, push, pop;
    rmq_item_t push_item, head;

    // classify and form radicand / numerators
    rmq_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_m00     (s_m00),
        .s_m01     (s_m01),
        .s_m02     (s_m02),
        .s_m10     (s_m10),
        .s_m11     (s_m11),
        .s_m12     (s_m12),
        .s_m20     (s_m20),
        .s_m21     (s_m21),
        .s_m22     (s_m22),
        .fifo_full (fifo_full),
        .push      (push),
        .push_item (push_item)
    );

    // decouple front and back so each may stall on its own
    rmq_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .full      (fifo_full),
        .empty     (fifo_empty),
        .head      (head)
    );

    // root, divide, saturate and hold the result
    rmq_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (!fifo_empty),
        .in_item     (head),
        .in_pop      (pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_quat_x    (m_quat_x),
        .m_quat_y    (m_quat_y),
        .m_quat_z    (m_quat_z),
        .m_quat_w    (m_quat_w),
        .m_saturated (m_saturated)
    );

endmodule

FILE: rtl/rmq_front.sv
// Front end: accepts a matrix, picks trace or pivot branch, forms radicand and numerators.
// Depends on rmq_pkg.
module rmq_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [rmq_pkg::IN_W-1:0] s_m00,
    input  logic signed [rmq_pkg::IN_W-1:0] s_m01,
    input  logic signed [rmq_pkg::IN_W-1:0] s_m02,
    input  logic signed [rmq_pkg::IN_W-1:0] s_m10,
    input  logic signed [rmq_pkg::IN_W-1:0] s_m11,
    input  logic signed [rmq_pkg::IN_W-1:0] s_m12,
    input  logic signed [rmq_pkg::IN_W-1:0] s_m20,
    input  logic signed [rmq_pkg::IN_W-1:0] s_m21,
    input  logic signed [rmq_pkg::IN_W-1:0] s_m22,
    input  logic                          fifo_full,
    output logic                          push,
    output rmq_pkg::rmq_item_t            push_item
);
    import rmq_pkg::*;

    localparam int EW = RAD_W + 1;

    logic      front_v_reg;
    rmq_item_t front_item_reg;
    rmq_item_t item_next;

    logic signed [EW-1:0] a00, a01, a02, a10, a11, a12, a20, a21, a22;
    logic signed [EW-1:0] tr, rsum, one_s;
    logic signed [EW-1:0] n0, n1, n2, n3;

    function automatic logic [MAG_W-1:0] mag_of(input logic signed [EW-1:0] v);
        logic signed [EW-1:0] a;
        a = (v < 0) ? -v : v;
        return a[MAG_W-1:0];
    endfunction

    assign a00   = EW'(s_m00);
    assign a01   = EW'(s_m01);
    assign a02   = EW'(s_m02);
    assign a10   = EW'(s_m10);
    assign a11   = EW'(s_m11);
    assign a12   = EW'(s_m12);
    assign a20   = EW'(s_m20);
    assign a21   = EW'(s_m21);
    assign a22   = EW'(s_m22);
    assign one_s = EW'(1) <<< FRAC_BITS;
    assign tr    = a00 + a11 + a22;

    always_comb begin
        // slots n0..n3 map to x, y, z, w
        n0   = '0;
        n1   = '0;
        n2   = '0;
        n3   = '0;
        rsum = '0;
        item_next = '0;
        if (tr > 0) begin
            item_next.num.root = COMP_W;
            rsum = tr + one_s;
            n0   = a21 - a12;
            n1   = a02 - a20;
            n2   = a10 - a01;
        end else if (a22 > ((a11 > a00) ? a11 : a00)) begin
            item_next.num.root = COMP_Z;
            rsum = a22 - (a00 + a11) + one_s;
            n3   = a10 - a01;
            n0   = a02 + a20;
            n1   = a12 + a21;
        end else if (a11 > a00) begin
            item_next.num.root = COMP_Y;
            rsum = a11 - (a22 + a00) + one_s;
            n3   = a02 - a20;
            n2   = a21 + a12;
            n0   = a01 + a10;
        end else begin
            item_next.num.root = COMP_X;
            rsum = a00 - (a11 + a22) + one_s;
            n3   = a21 - a12;
            n1   = a10 + a01;
            n2   = a20 + a02;
        end
        item_next.rad       = (rsum < 0) ? '0 : rsum[RAD_W-1:0];
        item_next.num.neg   = {n3 < 0, n2 < 0, n1 < 0, n0 < 0};
        item_next.num.mag[0] = mag_of(n0);
        item_next.num.mag[1] = mag_of(n1);
        item_next.num.mag[2] = mag_of(n2);
        item_next.num.mag[3] = mag_of(n3);
    end

    assign s_ready   = !front_v_reg || !fifo_full;
    assign push      = front_v_reg && !fifo_full;
    assign push_item = front_item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_v_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            front_v_reg <= 1'b1;
        end else if (push) begin
            front_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            front_item_reg <= item_next;
        end
    end

endmodule

FILE: rtl/rmq_fifo.sv
// Short show-ahead queue between front end and arithmetic back end.
// Depends on rmq_pkg.
module rmq_fifo (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  rmq_pkg::rmq_item_t push_item,
    input  logic               pop,
    output logic               full,
    output logic               empty,
    output rmq_pkg::rmq_item_t head
);
    import rmq_pkg::*;

    rmq_item_t            mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_AW:0]     count_reg;

    assign full  = (count_reg == (FIFO_AW+1)'(FIFO_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

FILE: rtl/rmq_back.sv
// Back end: pipelined square root, four pipelined restoring dividers, saturation, output register.
// Depends on rmq_pkg.
module rmq_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    input  rmq_pkg::rmq_item_t            in_item,
    output logic                          in_pop,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [rmq_pkg::OUT_W-1:0] m_quat_x,
    output logic signed [rmq_pkg::OUT_W-1:0] m_quat_y,
    output logic signed [rmq_pkg::OUT_W-1:0] m_quat_z,
    output logic signed [rmq_pkg::OUT_W-1:0] m_quat_w,
    output logic                          m_saturated
);
    import rmq_pkg::*;

    localparam int NS = RT_W;

    logic adv;

    // square-root stages
    logic [NS:0]        sq_v_reg, sq_v_next;
    logic [RM_W-1:0]    sq_rem_reg  [NS+1];
    logic [RM_W-1:0]    sq_rem_next [NS+1];
    logic [RT_W-1:0]    sq_root_reg [NS+1];
    logic [RT_W-1:0]    sq_root_next[NS+1];
    logic [SQ_W-1:0]    sq_rad_reg  [NS+1];
    logic [SQ_W-1:0]    sq_rad_next [NS+1];
    rmq_num_t           sq_num_reg  [NS+1];
    rmq_num_t           sq_num_next [NS+1];

    // divider stages
    logic [QB:0]                 dv_v_reg, dv_v_next;
    logic [3:0][DIV_W-1:0]       dv_rem_reg  [QB+1];
    logic [3:0][DIV_W-1:0]       dv_rem_next [QB+1];
    logic [3:0][QB-1:0]          dv_q_reg    [QB+1];
    logic [3:0][QB-1:0]          dv_q_next   [QB+1];
    logic [3:0]                  dv_ovf_reg  [QB+1];
    logic [3:0]                  dv_ovf_next [QB+1];
    logic [RT_W-1:0]             dv_s_reg    [QB+1];
    logic [RT_W-1:0]             dv_s_next   [QB+1];
    rmq_num_t                    dv_num_reg  [QB+1];
    rmq_num_t                    dv_num_next [QB+1];

    // output register
    logic                        m_valid_reg;
    logic [3:0][OUT_W-1:0]       quat_reg, quat_next;
    logic                        sat_reg, sat_next;

    assign adv    = !m_valid_reg || m_ready;
    assign in_pop = adv && in_valid;

    always_comb begin
        logic [RM_W-1:0]  rem2;
        logic [RM_W-1:0]  trial;
        logic [DIV_W-1:0] dsh;
        logic [RT_W-1:0]  half;
        logic [QB-1:0]    q;
        logic [RT_W-1:0]  s;

        // square root, one result bit per stage
        sq_v_next       = {sq_v_reg[NS-1:0], in_valid};
        sq_rem_next[0]  = '0;
        sq_root_next[0] = '0;
        sq_rad_next[0]  = SQ_W'({in_item.rad, {FRAC_BITS{1'b0}}});
        sq_num_next[0]  = in_item.num;
        for (int t = 1; t <= NS; t++) begin
            rem2  = {sq_rem_reg[t-1][RM_W-3:0], sq_rad_reg[t-1][SQ_W-1 -: 2]};
            trial = RM_W'({sq_root_reg[t-1], 2'b01});
            if (rem2 >= trial) begin
                sq_rem_next[t]  = rem2 - trial;
                sq_root_next[t] = {sq_root_reg[t-1][RT_W-2:0], 1'b1};
            end else begin
                sq_rem_next[t]  = rem2;
                sq_root_next[t] = {sq_root_reg[t-1][RT_W-2:0], 1'b0};
            end
            sq_rad_next[t] = sq_rad_reg[t-1] << 2;
            sq_num_next[t] = sq_num_reg[t-1];
        end

        // divider set-up: dividend and overflow test against 2s << QB
        dv_v_next      = {dv_v_reg[QB-1:0], sq_v_reg[NS]};
        dv_s_next[0]   = sq_root_reg[NS];
        dv_num_next[0] = sq_num_reg[NS];
        dsh = DIV_W'({sq_root_reg[NS], 1'b0}) << QB;
        for (int c = 0; c < 4; c++) begin
            dv_rem_next[0][c] = DIV_W'({sq_num_reg[NS].mag[c], {FRAC_BITS{1'b0}}});
            dv_q_next[0][c]   = '0;
            dv_ovf_next[0][c] = (dv_rem_next[0][c] >= dsh);
        end

        // restoring division, one quotient bit per stage
        for (int k = 1; k <= QB; k++) begin
            dsh = DIV_W'({dv_s_reg[k-1], 1'b0}) << (QB - k);
            for (int c = 0; c < 4; c++) begin
                if (dv_rem_reg[k-1][c] >= dsh) begin
                    dv_rem_next[k][c] = dv_rem_reg[k-1][c] - dsh;
                    dv_q_next[k][c]   = {dv_q_reg[k-1][c][QB-2:0], 1'b1};
                end else begin
                    dv_rem_next[k][c] = dv_rem_reg[k-1][c];
                    dv_q_next[k][c]   = {dv_q_reg[k-1][c][QB-2:0], 1'b0};
                end
            end
            dv_ovf_next[k] = dv_ovf_reg[k-1];
            dv_s_next[k]   = dv_s_reg[k-1];
            dv_num_next[k] = dv_num_reg[k-1];
        end

        // sign, saturate, place the root component
        s        = dv_s_reg[QB];
        half     = s >> 1;
        sat_next = 1'b0;
        for (int c = 0; c < 4; c++) begin
            q = dv_q_reg[QB][c];
            if (dv_num_reg[QB].root == comp_t'(2'(c))) begin
                if (half > RT_W'(OUT_MAX)) begin
                    quat_next[c] = OUT_W'(OUT_MAX);
                    sat_next     = 1'b1;
                end else begin
                    quat_next[c] = OUT_W'(half);
                end
            end else if (s == '0) begin
                quat_next[c] = '0;
            end else if (dv_num_reg[QB].neg[c]) begin
                if (dv_ovf_reg[QB][c] || q > QB'(OUT_MAX + 1)) begin
                    quat_next[c] = OUT_W'(OUT_MAX + 1);
                    sat_next     = 1'b1;
                end else begin
                    quat_next[c] = OUT_W'(-q);
                end
            end else begin
                if (dv_ovf_reg[QB][c] || q > QB'(OUT_MAX)) begin
                    quat_next[c] = OUT_W'(OUT_MAX);
                    sat_next     = 1'b1;
                end else begin
                    quat_next[c] = OUT_W'(q);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_v_reg    <= '0;
            dv_v_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            sq_v_reg    <= sq_v_next;
            dv_v_reg    <= dv_v_next;
            m_valid_reg <= dv_v_reg[QB];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int t = 0; t <= NS; t++) begin
                sq_rem_reg[t]  <= sq_rem_next[t];
                sq_root_reg[t] <= sq_root_next[t];
                sq_rad_reg[t]  <= sq_rad_next[t];
                sq_num_reg[t]  <= sq_num_next[t];
            end
            for (int k = 0; k <= QB; k++) begin
                dv_rem_reg[k] <= dv_rem_next[k];
                dv_q_reg[k]   <= dv_q_next[k];
                dv_ovf_reg[k] <= dv_ovf_next[k];
                dv_s_reg[k]   <= dv_s_next[k];
                dv_num_reg[k] <= dv_num_next[k];
            end
            quat_reg <= quat_next;
            sat_reg  <= sat_next;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_quat_x    = quat_reg[0];
    assign m_quat_y    = quat_reg[1];
    assign m_quat_z    = quat_reg[2];
    assign m_quat_w    = quat_reg[3];
    assign m_saturated = sat_reg;

endmodule

FILE: rtl/rmq_checker.sv
// Port-level checks of the quaternion converter, bound to the top level.
// Depends on rmq_pkg and rotation_matrix_to_quaternion.
module rmq_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [rmq_pkg::OUT_W-1:0]     m_quat_x,
    input logic [rmq_pkg::OUT_W-1:0]     m_quat_y,
    input logic [rmq_pkg::OUT_W-1:0]     m_quat_z,
    input logic [rmq_pkg::OUT_W-1:0]     m_quat_w,
    input logic                          m_saturated
);
    import rmq_pkg::*;

    localparam logic [OUT_W-1:0] PMAX = OUT_W'(OUT_MAX);
    localparam logic [OUT_W-1:0] NMAX = OUT_W'(OUT_MAX + 1);

    // hold a stalled result
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_quat_x) && $stable(m_quat_y)
            && $stable(m_quat_z) && $stable(m_quat_w) && $stable(m_saturated))
        else $error("stalled result changed");

    // reset empties the pipeline and opens the input
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("reset did not empty the block");

    // a clipped result carries at least one component at a rail
    a_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_saturated |->
            m_quat_x == PMAX || m_quat_x == NMAX || m_quat_y == PMAX || m_quat_y == NMAX ||
            m_quat_z == PMAX || m_quat_z == NMAX || m_quat_w == PMAX || m_quat_w == NMAX)
        else $error("saturation flag without a clipped component");

endmodule

bind rotation_matrix_to_quaternion rmq_checker u_rmq_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_quat_x    (m_quat_x),
    .m_quat_y    (m_quat_y),
    .m_quat_z    (m_quat_z),
    .m_quat_w    (m_quat_w),
    .m_saturated (m_saturated)
);

FILE: dv/tb_top.sv
// Self-checking testbench of the rotation-matrix to quaternion converter.
// Depends on rmq_pkg and rotation_matrix_to_quaternion; predicts each quaternion itself unless a row types it in.
module tb_top;
    import rmq_pkg::*;

    localparam int ONE       = 1 << FRAC_BITS;
    localparam int N_RANDOM  = 800;
    localparam int WD_LIMIT  = 20000;
    localparam int DRAIN     = 60;

    typedef logic signed [IN_W-1:0] elem_t;

    typedef struct {
        elem_t m [9];
    } matrix_t;

    typedef struct {
        logic signed [OUT_W-1:0] x, y, z, w;
        logic                    sat;
    } quat_t;

    // Directed stimulus row; known marks a row whose result is typed in
    typedef struct {
        matrix_t mat;
        bit      known;
        quat_t   res;
    } row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    elem_t s_m [9];
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [OUT_W-1:0] m_quat_x, m_quat_y, m_quat_z, m_quat_w;
    logic m_saturated;

    quat_t pending_quats [$];
    int    mismatches = 0;
    int    idle_cycles = 0;
    bit    hold_off = 1'b0;
    bit    cur_known = 1'b0;
    quat_t cur_res;

    initial for (int n = 0; n < 9; n++) s_m[n] = '0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    rotation_matrix_to_quaternion dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_m00(s_m[0]), .s_m01(s_m[1]), .s_m02(s_m[2]),
        .s_m10(s_m[3]), .s_m11(s_m[4]), .s_m12(s_m[5]),
        .s_m20(s_m[6]), .s_m21(s_m[7]), .s_m22(s_m[8]),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_quat_x(m_quat_x), .m_quat_y(m_quat_y), .m_quat_z(m_quat_z),
        .m_quat_w(m_quat_w), .m_saturated(m_saturated)
    );

    // Integer square root, rounded down
    function automatic longint unsigned floor_sqrt(longint unsigned v);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= root + bitv) begin
                v -= root + bitv;
                root = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        return root;
    endfunction

    // n * ONE / (2 * root), truncated toward zero; zero for a zero root
    function automatic longint div_by_root(longint n, longint unsigned root);
        longint unsigned mag;
        longint unsigned quo;
        if (root == 0) return 0;
        mag = (n < 0) ? longint'(-n) : n;
        quo = (mag << FRAC_BITS) / (2 * root);
        return (n < 0) ? -longint'(quo) : longint'(quo);
    endfunction

    function automatic logic signed [OUT_W-1:0] clip(longint v, inout logic sat);
        if (v > 32767) begin
            sat = 1'b1;
            return 16'sh7fff;
        end
        if (v < -32768) begin
            sat = 1'b1;
            return 16'sh8000;
        end
        return v[OUT_W-1:0];
    endfunction

    // Shepperd conversion: trace branch or pivot on the largest diagonal
    function automatic quat_t shepperd_quat(matrix_t mat);
        longint a [3][3];
        longint comp [4];
        longint tr, rad;
        longint unsigned root;
        int piv, j, k;
        quat_t res;
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++) a[r][c] = mat.m[r*3+c];
        tr = a[0][0] + a[1][1] + a[2][2];
        if (tr > 0) begin
            rad = tr + ONE;
            root = floor_sqrt(longint'(rad) << FRAC_BITS);
            comp[3] = root >> 1;
            comp[0] = div_by_root(a[2][1] - a[1][2], root);
            comp[1] = div_by_root(a[0][2] - a[2][0], root);
            comp[2] = div_by_root(a[1][0] - a[0][1], root);
        end else begin
            piv = 0;
            if (a[1][1] > a[0][0]) piv = 1;
            if (a[2][2] > a[piv][piv]) piv = 2;
            j = (piv + 1) % 3;
            k = (j + 1) % 3;
            rad = a[piv][piv] - (a[j][j] + a[k][k]) + ONE;
            if (rad < 0) rad = 0;
            root = floor_sqrt(longint'(rad) << FRAC_BITS);
            comp[piv] = root >> 1;
            comp[3] = div_by_root(a[k][j] - a[j][k], root);
            comp[j] = div_by_root(a[j][piv] + a[piv][j], root);
            comp[k] = div_by_root(a[k][piv] + a[piv][k], root);
        end
        res.sat = 1'b0;
        res.x = clip(comp[0], res.sat);
        res.y = clip(comp[1], res.sat);
        res.z = clip(comp[2], res.sat);
        res.w = clip(comp[3], res.sat);
        return res;
    endfunction

    function automatic matrix_t mk(int e0, int e1, int e2, int e3, int e4,
                                   int e5, int e6, int e7, int e8);
        matrix_t mat;
        mat.m = '{elem_t'(e0), elem_t'(e1), elem_t'(e2), elem_t'(e3), elem_t'(e4),
                  elem_t'(e5), elem_t'(e6), elem_t'(e7), elem_t'(e8)};
        return mat;
    endfunction

    function automatic quat_t qk(int x, int y, int z, int w, bit sat);
        quat_t q;
        q.x = OUT_W'(x); q.y = OUT_W'(y); q.z = OUT_W'(z); q.w = OUT_W'(w); q.sat = sat;
        return q;
    endfunction

    // Random matrix: full-range, rail or unit-range elements, or near a rotation with a random pivot
    function automatic matrix_t random_matrix();
        matrix_t mat;
        int kind;
        kind = $urandom_range(0, 9);
        for (int n = 0; n < 9; n++) begin
            if (kind == 0) mat.m[n] = elem_t'($urandom());
            else if (kind == 1) mat.m[n] = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            else mat.m[n] = elem_t'($signed($urandom_range(0, 2*ONE)) - ONE);
        end
        if (kind >= 7) begin
            // near identity, or near a half-turn about one axis
            int ax;
            ax = $urandom_range(0, 3);
            for (int n = 0; n < 9; n++)
                mat.m[n] = elem_t'($signed($urandom_range(0, 2000)) - 1000);
            for (int d = 0; d < 3; d++)
                mat.m[d*4] = (ax == 3 || ax == d) ? elem_t'(ONE - $urandom_range(0, 500))
                                                  : elem_t'(-ONE + $urandom_range(0, 500));
        end
        return mat;
    endfunction

    task automatic gap(int most);
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, most) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) n = 0;
        repeat (n) @(negedge aclk);
    endtask

    // Offer one matrix, hold until the transfer happens
    task automatic send_matrix(matrix_t mat);
        s_m = mat.m;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    // Predict at acceptance so the store follows the input order
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            matrix_t mat;
            mat.m = s_m;
            if (cur_known) pending_quats.push_back(cur_res);
            else pending_quats.push_back(shepperd_quat(mat));
        end
    end

    // Compare every result transfer against the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            quat_t exp_q;
            if (pending_quats.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected quaternion at %0t", $realtime);
            end else begin
                exp_q = pending_quats.pop_front();
                if (exp_q.x !== m_quat_x || exp_q.y !== m_quat_y || exp_q.z !== m_quat_z ||
                    exp_q.w !== m_quat_w || exp_q.sat !== m_saturated) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp %0d %0d %0d %0d %0b, got %0d %0d %0d %0d %0b",
                                 exp_q.x, exp_q.y, exp_q.z, exp_q.w, exp_q.sat,
                                 m_quat_x, m_quat_y, m_quat_z, m_quat_w, m_saturated);
                end
            end
        end
    end

    // Watchdog: count cycles with no transfer on either side
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WD_LIMIT) begin
            $display("rotation_matrix_to_quaternion test failed");
            $finish;
        end
    end

    // Receiver: random stalls, plus one long hold-off while the sender runs
    initial begin
        @(posedge aresetn);
        while (1) begin
            @(negedge aclk);
            if (hold_off) begin
                m_ready <= 1'b0;
                repeat (200) @(negedge aclk);
                hold_off = 1'b0;
                m_ready <= 1'b1;
            end else if ($urandom_range(0, 4) == 0) begin
                m_ready <= 1'b0;
                @(negedge aclk);
                gap(40);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        row_t rows [$];
        row_t rw;
        int drain;
        // identity, zero matrix, extremes, pivot ties, half-turns
        rw.known = 1; rw.mat = mk(ONE,0,0, 0,ONE,0, 0,0,ONE);
        rw.res = qk(0,0,0,16384,0); rows.push_back(rw);
        rw.known = 1; rw.mat = mk(0,0,0, 0,0,0, 0,0,0);
        rw.res = qk(8192,0,0,0,0); rows.push_back(rw);
        rw.known = 1; rw.mat = mk(-ONE,0,0, 0,-ONE,0, 0,0,-ONE);
        rw.res = qk(11585,0,0,0,0); rows.push_back(rw);
        rw.known = 0;
        rw.mat = mk(ONE,0,0, 0,-ONE,0, 0,0,-ONE); rows.push_back(rw);
        rw.mat = mk(-ONE,0,0, 0,ONE,0, 0,0,-ONE); rows.push_back(rw);
        rw.mat = mk(-ONE,0,0, 0,-ONE,0, 0,0,ONE); rows.push_back(rw);
        rw.mat = mk(0,-ONE,0, ONE,0,0, 0,0,ONE); rows.push_back(rw);
        rw.mat = mk(-5,ONE,ONE, ONE,-5,ONE, ONE,ONE,-5); rows.push_back(rw);
        rw.mat = mk(-ONE,ONE,-ONE, -ONE,-ONE,ONE, ONE,ONE,-ONE); rows.push_back(rw);
        rw.mat = mk(1,32767,-32768, -32768,1,32767, 32767,-32768,1); rows.push_back(rw);
        rw.mat = mk(32767,32767,32767, 32767,32767,32767, 32767,32767,32767);
        rows.push_back(rw);
        rw.mat = mk(-32768,-32768,-32768, -32768,-32768,-32768, -32768,-32768,-32768);
        rows.push_back(rw);
        rw.mat = mk(-32768,32767,-32768, 32767,-32768,32767, -32768,32767,32767);
        rows.push_back(rw);
        rw.mat = mk(1,-32768,32767, 32767,0,-32768, -32768,32767,0); rows.push_back(rw);
        rw.mat = mk(-100,0,0, 0,-200,ONE, 0,ONE,-300); rows.push_back(rw);
        rw.mat = mk(-100,ONE,0, ONE,-100,0, 0,0,-100); rows.push_back(rw);
        rw.mat = mk(0,-1,1, 1,0,-1, -1,1,0); rows.push_back(rw);

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (rows[n]) begin
            cur_known = rows[n].known;
            cur_res = rows[n].res;
            send_matrix(rows[n].mat);
            s_valid <= 1'b0;
            cur_known = 1'b0;
            @(negedge aclk);
            gap(20);
        end

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == 300) hold_off = 1'b1;
            send_matrix(random_matrix());
            // drop valid only when a gap follows, keep it high otherwise
            if ($urandom_range(0, 2) == 0) begin
                s_valid <= 1'b0;
                @(negedge aclk);
                gap(30);
            end
        end
        s_valid <= 1'b0;

        drain = 0;
        while (pending_quats.size() != 0 && drain < 100000) begin
            @(posedge aclk);
            drain++;
        end
        repeat (DRAIN) @(posedge aclk);
        if (mismatches == 0 && pending_quats.size() == 0)
            $display("rotation_matrix_to_quaternion test passed");
        else
            $display("rotation_matrix_to_quaternion test failed");
        $finish;
    end

endmodule
